// ===== hw/rtl/anid_pkg.sv =====
// ----------------------------------------------------------------------------
// anid_pkg
// Shared types, phase codes and the code alphabet for the article name to
// id code block.
// ----------------------------------------------------------------------------
package anid_pkg;

	localparam int NameLimitDef = 32;
	localparam int IdW          = 48;
	localparam int DecW         = 32;
	localparam int HexW         = 12;
	localparam int SymW         = 6;
	localparam int NumSyms      = IdW / SymW;
	localparam int SymIdxW      = $clog2(NumSyms);
	localparam int PhaseW       = 3;

	localparam logic [PhaseW-1:0] PH_TYPE     = 3'd0;
	localparam logic [PhaseW-1:0] PH_DOT1     = 3'd1;
	localparam logic [PhaseW-1:0] PH_DEC      = 3'd2;
	localparam logic [PhaseW-1:0] PH_LETTER_A = 3'd3;
	localparam logic [PhaseW-1:0] PH_AFTER_A  = 3'd4;
	localparam logic [PhaseW-1:0] PH_HEX      = 3'd5;
	localparam logic [PhaseW-1:0] PH_DONE     = 3'd6;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_M   = 8'h4d;
	localparam logic [7:0] CH_G   = 8'h47;
	localparam logic [7:0] CH_A   = 8'h41;

	typedef struct packed {
		logic [7:0] char_code;
	} char_item_t;

	typedef struct packed {
		logic [6:0]     code_char;
		logic           is_last;
		logic [IdW-1:0] packed_id;
		logic           name_valid;
	} code_item_t;

	function automatic logic [6:0] sym_to_char(input logic [SymW-1:0] sym);
		logic [6:0] ch;
		ch = 7'h5f;
		case (sym) inside
			[6'd0 : 6'd9]:   ch = 7'h30 + {1'b0, sym};
			[6'd10 : 6'd35]: ch = 7'h41 + {1'b0, sym} - 7'd10;
			[6'd36 : 6'd61]: ch = 7'h61 + {1'b0, sym} - 7'd36;
			6'd62:           ch = 7'h2d;
			default:         ch = 7'h5f;
		endcase
		return ch;
	endfunction

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		case (c) inside
			[8'h30 : 8'h39]: r = {1'b0, c[3:0]};
			[8'h41 : 8'h46],
			[8'h61 : 8'h66]: r = {1'b0, c[3:0] + 4'd9};
			default:         r = 5'h10;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/anid_stream_if.sv =====
// ----------------------------------------------------------------------------
// anid_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface anid_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/article_name_to_id_code_top.sv =====
// ----------------------------------------------------------------------------
// article_name_to_id_code_top
// Parses an article file name byte by byte and, on NUL, emits the packed
// 48-bit id as eight characters of a 64-symbol alphabet.
// ----------------------------------------------------------------------------
// channel | dir | payload                                      | per transfer
// chars   | in  | char_code                                    | one name byte
// codes   | out | code_char, is_last, packed_id, name_valid    | one id char
//
// A non-NUL byte only updates the parse state.
// A NUL produces eight output transfers, one per cycle while codes.ready.
// One finished id waits in a pending slot, so parsing of the next name goes
// on during emission; chars.ready drops only while that slot is full.
// arst_n clears the parse state, the emitter and the pending slot.
// ----------------------------------------------------------------------------
module article_name_to_id_code_top #(
	parameter int NAME_LIMIT = anid_pkg::NameLimitDef
) (
	input  logic         clk,
	input  logic         arst_n,
	anid_stream_if.sink   chars,
	anid_stream_if.source codes
);
	import anid_pkg::*;

	localparam int CntW = $clog2(NAME_LIMIT + 1);

	logic [PhaseW-1:0]  phase_q;
	logic               type_q;
	logic [DecW-1:0]    dec_q;
	logic [HexW-1:0]    hex_q;
	logic [CntW-1:0]    cnt_q;
	logic               ok_q;

	logic               busy_q;
	logic [SymIdxW-1:0] idx_q;
	logic [IdW-1:0]     id_q;
	logic               valid_q;

	logic               pend_q;
	logic [IdW-1:0]     pend_id_q;
	logic               pend_valid_q;

	logic               acc_in;
	logic               nul_in;
	logic               take;
	logic [7:0]         c;
	logic [4:0]         hd;
	logic [DecW+3:0]    dec_acc;
	logic [DecW-1:0]    dec_next;
	logic               name_ok;
	logic [IdW-1:0]     id_new;
	logic               done_out;
	logic               emit_free;

	assign c        = chars.payload.char_code;
	assign acc_in   = chars.valid && chars.ready;
	assign nul_in   = acc_in && (c == CH_NUL);
	assign take     = acc_in && (c != CH_NUL) && ok_q &&
		(cnt_q < CntW'(NAME_LIMIT));
	assign hd       = hex_digit(c);
	assign dec_acc  = {1'b0, dec_q, 3'b000} + {3'b000, dec_q, 1'b0} +
		{{(DecW){1'b0}}, c[3:0]};
	assign dec_next = (dec_acc[DecW+3:DecW] != 4'd0) ? {DecW{1'b1}} : dec_acc[DecW-1:0];
	assign name_ok  = ok_q && (phase_q >= PH_AFTER_A);
	assign id_new   = name_ok ?
		{3'b000, type_q, dec_q, hex_q} : {IdW{1'b0}};

	assign done_out  = busy_q && codes.ready && (idx_q == SymIdxW'(NumSyms - 1));
	assign emit_free = !busy_q || done_out;

	assign chars.ready = !pend_q;

	assign codes.valid              = busy_q;
	assign codes.payload.code_char  =
		sym_to_char(id_q[SymW*(NumSyms-1-int'(idx_q)) +: SymW]);
	assign codes.payload.is_last    = (idx_q == SymIdxW'(NumSyms - 1));
	assign codes.payload.packed_id  = id_q;
	assign codes.payload.name_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			type_q  <= 1'b0;
			dec_q   <= '0;
			hex_q   <= '0;
			cnt_q   <= '0;
			ok_q    <= 1'b1;
		end else if (nul_in) begin
			phase_q <= PH_TYPE;
			type_q  <= 1'b0;
			dec_q   <= '0;
			hex_q   <= '0;
			cnt_q   <= '0;
			ok_q    <= 1'b1;
		end else if (take) begin
			cnt_q <= cnt_q + CntW'(1);
			case (phase_q)
				PH_TYPE: begin
					if (c == CH_M) begin
						type_q  <= 1'b0;
						phase_q <= PH_DOT1;
					end else if (c == CH_G) begin
						type_q  <= 1'b1;
						phase_q <= PH_DOT1;
					end else begin
						ok_q <= 1'b0;
					end
				end
				PH_DOT1: begin
					if (c == CH_DOT) begin
						phase_q <= PH_DEC;
					end else begin
						ok_q <= 1'b0;
					end
				end
				PH_DEC: begin
					if (c inside {[8'h30 : 8'h39]}) begin
						dec_q <= dec_next;
					end else if (c == CH_DOT) begin
						phase_q <= PH_LETTER_A;
					end else begin
						ok_q <= 1'b0;
					end
				end
				PH_LETTER_A: begin
					if (c == CH_A) begin
						phase_q <= PH_AFTER_A;
					end else begin
						ok_q <= 1'b0;
					end
				end
				PH_AFTER_A: begin
					phase_q <= (c == CH_DOT) ? PH_HEX : PH_DONE;
				end
				PH_HEX: begin
					if (!hd[4]) begin
						hex_q <= {hex_q[HexW-5:0], hd[3:0]};
					end else begin
						phase_q <= PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end else if (acc_in && ok_q && (cnt_q < CntW'(NAME_LIMIT))) begin
			cnt_q <= cnt_q + CntW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			if (nul_in && emit_free) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (done_out && pend_q) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else if (done_out) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				if (busy_q && codes.ready) begin
					idx_q <= idx_q + SymIdxW'(1);
				end
				if (nul_in) begin
					pend_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (nul_in && emit_free) begin
			id_q    <= id_new;
			valid_q <= name_ok;
		end else if (done_out && pend_q) begin
			id_q    <= pend_id_q;
			valid_q <= pend_valid_q;
		end
		if (nul_in && !emit_free) begin
			pend_id_q    <= id_new;
			pend_valid_q <= name_ok;
		end
	end

	a_pend_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> busy_q)
		else $error("pending id held while emitter idle");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done_out && !pend_q && !nul_in) |=> !codes.valid)
		else $error("output still valid after last character");

	a_bad_name_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(codes.valid && !codes.payload.name_valid) |-> (codes.payload.packed_id == '0))
		else $error("mismatched name gives nonzero id");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(NAME_LIMIT))
		else $error("character count beyond limit");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the article name to id code block. Feeds file names one
// byte per transfer, each ended by NUL. It opens with a table of
// hand-picked names, some with their ids written out, then sends random,
// mostly well-formed names while the input side idles and the output side
// stalls in turn. A parser model inside the bench builds the eight code
// characters that each name should produce. Every output transfer is
// compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import anid_pkg::*;

	localparam int NameLimit   = NameLimitDef;
	localparam int CycleLimit  = 400000;
	localparam int TotalBytes  = 480;
	localparam int MaxPrinted  = 40;

	typedef struct {
		bit             pinned;
		logic [IdW-1:0] id;
		bit             ok;
	} id_pin_t;

	typedef struct {
		string   text;
		id_pin_t pin;
	} name_case_t;

	logic clk = 1'b0;
	logic arst_n;

	anid_stream_if #(.T(char_item_t)) chars_if ();
	anid_stream_if #(.T(code_item_t)) codes_if ();

	article_name_to_id_code_top #(
		.NAME_LIMIT(NameLimit)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.chars(chars_if),
		.codes(codes_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	string code_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz-_";

	logic [PhaseW-1:0] parse_ph;
	logic              kind_bit;
	logic [DecW-1:0]   dec_val;
	logic [HexW-1:0]   hex_val;
	logic [5:0]        name_len;
	logic              form_ok;

	code_item_t  pending_codes[$];
	id_pin_t     name_pins[$];
	name_case_t  dir_cases[$];
	logic [7:0]  name_bytes[$];

	int send_idle_pct[4] = '{0, 46, 0, 28};
	int recv_stall_pct[4] = '{0, 0, 46, 28};
	int send_idle;
	int recv_stall;
	int err_count;
	int parsed_count;
	int bytes_sent;
	int names_sent;
	int valid_names;
	int codes_checked;
	int cycle_count;

	function automatic void clear_parse();
		parse_ph = PH_TYPE;
		kind_bit = 1'b0;
		dec_val  = '0;
		hex_val  = '0;
		name_len = '0;
		form_ok  = 1'b1;
	endfunction

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	// advance the parse by one name byte; tell whether it mattered
	function automatic bit absorb_char(input logic [7:0] c);
		logic [63:0] acc;
		int          nib;
		bit          used;
		used = (name_len < NameLimit) && form_ok && (parse_ph < PH_DONE);
		if (name_len < NameLimit) begin
			name_len = name_len + 6'd1;
			if (form_ok) begin
				case (parse_ph)
					PH_TYPE: begin
						if (c == CH_M) begin
							kind_bit = 1'b0;
							parse_ph = PH_DOT1;
						end else if (c == CH_G) begin
							kind_bit = 1'b1;
							parse_ph = PH_DOT1;
						end else begin
							form_ok = 1'b0;
						end
					end
					PH_DOT1: begin
						if (c == CH_DOT) parse_ph = PH_DEC;
						else form_ok = 1'b0;
					end
					PH_DEC: begin
						if (c >= "0" && c <= "9") begin
							acc = {32'd0, dec_val} * 64'd10 + 64'(c - "0");
							dec_val = (acc > 64'hffff_ffff) ? '1 : acc[31:0];
						end else if (c == CH_DOT) begin
							parse_ph = PH_LETTER_A;
						end else begin
							form_ok = 1'b0;
						end
					end
					PH_LETTER_A: begin
						if (c == CH_A) parse_ph = PH_AFTER_A;
						else form_ok = 1'b0;
					end
					PH_AFTER_A: begin
						parse_ph = (c == CH_DOT) ? PH_HEX : PH_DONE;
					end
					PH_HEX: begin
						nib = nibble_of(c);
						if (nib >= 0) hex_val = {hex_val[HexW-5:0], 4'(nib)};
						else parse_ph = PH_DONE;
					end
					default: begin
					end
				endcase
			end
		end
		return used;
	endfunction

	// finish the name: queue its eight code characters
	function automatic void close_name(input id_pin_t pin);
		logic [IdW-1:0]  id;
		bit              ok;
		code_item_t      item;
		logic [SymW-1:0] sym;
		logic [7:0]      ch;
		ok = form_ok && (parse_ph >= PH_AFTER_A);
		id = ok ? {3'b000, kind_bit, dec_val, hex_val} : '0;
		if (pin.pinned) begin
			id = pin.id;
			ok = pin.ok;
		end
		if (ok) valid_names++;
		for (int k = 0; k < NumSyms; k++) begin
			sym = id[IdW-1-SymW*k -: SymW];
			ch = code_set[sym];
			item.code_char  = ch[6:0];
			item.is_last    = (k == NumSyms - 1);
			item.packed_id  = id;
			item.name_valid = ok;
			pending_codes.push_back(item);
		end
		clear_parse();
	endfunction

	task automatic report_mismatch(input string what, input logic [IdW-1:0] got,
			input logic [IdW-1:0] want);
		err_count++;
		if (err_count <= MaxPrinted)
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	task automatic check_code(input code_item_t got);
		code_item_t want;
		if (pending_codes.size() == 0) begin
			report_mismatch("unexpected transfer, packed_id", got.packed_id, '0);
			return;
		end
		want = pending_codes.pop_front();
		codes_checked++;
		if (got.code_char !== want.code_char)
			report_mismatch("code_char", IdW'(got.code_char), IdW'(want.code_char));
		if (got.is_last !== want.is_last)
			report_mismatch("is_last", IdW'(got.is_last), IdW'(want.is_last));
		if (got.packed_id !== want.packed_id)
			report_mismatch("packed_id", got.packed_id, want.packed_id);
		if (got.name_valid !== want.name_valid)
			report_mismatch("name_valid", IdW'(got.name_valid), IdW'(want.name_valid));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready) begin
				if (chars_if.payload.char_code == CH_NUL) begin
					close_name(name_pins.pop_front());
					parsed_count++;
				end else if (absorb_char(chars_if.payload.char_code)) begin
					parsed_count++;
				end
			end
			if (codes_if.valid && codes_if.ready) check_code(codes_if.payload);
		end
	end

	always @(posedge clk) begin
		codes_if.ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("[%0t] timeout with %0d code transfers outstanding", $realtime,
				pending_codes.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void add_case(input string text, input bit pinned,
			input logic [IdW-1:0] id, input bit ok);
		name_case_t c;
		c.text = text;
		c.pin.pinned = pinned;
		c.pin.id = id;
		c.pin.ok = ok;
		dir_cases.push_back(c);
	endfunction

	task automatic send_byte(input logic [7:0] c);
		while ($urandom_range(0, 99) < send_idle) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.payload.char_code <= c;
		do @(posedge clk); while (!chars_if.ready);
		bytes_sent++;
	endtask

	task automatic send_name(input id_pin_t pin);
		name_pins.push_back(pin);
		foreach (name_bytes[i]) send_byte(name_bytes[i]);
		send_byte(CH_NUL);
		names_sent++;
	endtask

	task automatic push_form(input bit long_name);
		int    ndig;
		int    nhex;
		string hex_chars = "0123456789abcdefABCDEF";
		name_bytes.push_back($urandom_range(0, 1) ? CH_G : CH_M);
		name_bytes.push_back(CH_DOT);
		ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
		if (long_name && $urandom_range(0, 1)) ndig = $urandom_range(28, 40);
		repeat (ndig) name_bytes.push_back(8'("0" + $urandom_range(0, 9)));
		name_bytes.push_back(CH_DOT);
		name_bytes.push_back(CH_A);
		case ($urandom_range(0, 3))
			0: begin
			end
			1, 2: begin
				name_bytes.push_back(CH_DOT);
				nhex = long_name ? $urandom_range(20, 40) : $urandom_range(0, 5);
				repeat (nhex) name_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
				if ($urandom_range(0, 1)) name_bytes.push_back(8'($urandom_range(1, 255)));
			end
			default: begin
				name_bytes.push_back(8'($urandom_range(1, 255)));
			end
		endcase
		repeat ($urandom_range(0, 2)) name_bytes.push_back(8'($urandom_range(1, 255)));
	endtask

	task automatic build_random_name();
		int kind;
		name_bytes.delete();
		kind = $urandom_range(0, 9);
		if (kind == 9) begin
			repeat ($urandom_range(0, 12)) name_bytes.push_back(8'($urandom_range(1, 255)));
		end else begin
			push_form(kind == 7);
			if (kind == 8)
				name_bytes[$urandom_range(0, name_bytes.size() - 1)] = 8'($urandom_range(1, 255));
		end
	endtask

	initial begin
		id_pin_t free_pin;
		int      dir_sent;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.payload = '0;
		codes_if.ready = 1'b0;
		send_idle = 0;
		recv_stall = 0;
		clear_parse();

		add_case("", 1'b1, 48'h0, 1'b0);
		add_case("M.0.A", 1'b1, 48'h0, 1'b1);
		add_case("G.4294967295.A.fff", 1'b1, 48'h1fff_ffff_ffff, 1'b1);
		add_case("M.99999999999.A", 1'b1, 48'h0fff_ffff_f000, 1'b1);
		add_case("G..A", 1'b1, 48'h1000_0000_0000, 1'b1);
		add_case("X.1.A", 1'b1, 48'h0, 1'b0);
		add_case("M1.A", 1'b1, 48'h0, 1'b0);
		add_case("M.12x.A", 1'b1, 48'h0, 1'b0);
		add_case("M.5.B", 1'b1, 48'h0, 1'b0);
		add_case("M.0x1F.A", 1'b1, 48'h0, 1'b0);
		add_case("G. 7.A", 1'b1, 48'h0, 1'b0);
		add_case("M.+7.A", 1'b1, 48'h0, 1'b0);
		add_case("M.12", 1'b1, 48'h0, 1'b0);
		add_case("M.123456789012345678901234567890.A", 1'b1, 48'h0, 1'b0);
		add_case("M.\377\200.A", 1'b1, 48'h0, 1'b0);
		add_case("M.5.A.aBc1", 1'b0, 48'h0, 1'b0);
		add_case("G.7.Az.q", 1'b0, 48'h0, 1'b0);
		add_case("M.3.A.12g45", 1'b0, 48'h0, 1'b0);
		add_case("M.3.A.", 1'b0, 48'h0, 1'b0);
		add_case("G.1.A\377", 1'b0, 48'h0, 1'b0);
		add_case("G.1.A.0123456789abcdefABCDEF0123456789abcdef", 1'b0, 48'h0, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_cases[i]) begin
			name_bytes.delete();
			for (int j = 0; j < dir_cases[i].text.len(); j++)
				name_bytes.push_back(dir_cases[i].text[j]);
			send_name(dir_cases[i].pin);
		end

		free_pin.pinned = 1'b0;
		free_pin.id = '0;
		free_pin.ok = 1'b0;
		dir_sent = bytes_sent;
		for (int p = 0; p < 4; p++) begin
			send_idle = send_idle_pct[p];
			recv_stall = recv_stall_pct[p];
			while (bytes_sent < dir_sent + (p + 1) * (TotalBytes - dir_sent) / 4) begin
				build_random_name();
				send_name(free_pin);
			end
		end
		chars_if.valid <= 1'b0;

		while (pending_codes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d names sent (%0d well formed) in %0d bytes, %0d parsed bytes and NULs",
			names_sent, valid_names, bytes_sent, parsed_count);
		$display("%0d code characters checked over four idle/stall mixes, %0d mismatches",
			codes_checked, err_count);
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/anid_pkg.sv
hw/rtl/anid_stream_if.sv
hw/rtl/article_name_to_id_code_top.sv
dv/tb_top.sv
